// ===== src/ddd_pkg.sv =====
// ----------------------------------------------------------------------------
// ddd_pkg
// Types, widths and constants shared by the date difference pipeline.
// ----------------------------------------------------------------------------
package ddd_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int DIFF_W   = 23;
   localparam int COUNT_W  = 23;
   localparam int CENT_W   = 8;
   localparam int QUAD_W   = 13;
   localparam int ERA_W    = 6;
   localparam int DOY_W    = 9;
   localparam int SUM_W    = YEAR_W + 1;
   localparam int PROD_W   = 2 * SUM_W;
   localparam int RECIP_SHIFT = 21;

   // ceil(2^21 / 100), exact for sums below 2^15
   localparam logic [SUM_W-1:0] RECIP_100 = 15'd20972;
   localparam logic [SUM_W-1:0] CENT_ROUND = 15'd99;
   localparam logic [SUM_W-1:0] QUAD_ROUND = 15'd3;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DIFF_W-1:0] DIFF_MAX = 23'h3f_ffff;
   localparam logic [DIFF_W-1:0] DIFF_MIN = 23'h40_0000;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   // days before the month; month zero counts nothing
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
      logic [DOY_W-1:0] days;
      case (month)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ===== src/ddd_channels.sv =====
// ----------------------------------------------------------------------------
// ddd channels
// Valid/ready channels for date pairs and day differences.
// ----------------------------------------------------------------------------
interface ddd_req_if;
   logic                         valid;
   logic                         ready;
   logic [ddd_pkg::YEAR_W-1:0]   first_year;
   logic [ddd_pkg::MONTH_W-1:0]  first_month;
   logic [ddd_pkg::DAY_W-1:0]    first_day;
   logic [ddd_pkg::YEAR_W-1:0]   second_year;
   logic [ddd_pkg::MONTH_W-1:0]  second_month;
   logic [ddd_pkg::DAY_W-1:0]    second_day;

   modport source (
      output valid, first_year, first_month, first_day,
             second_year, second_month, second_day,
      input  ready
   );
   modport sink (
      input  valid, first_year, first_month, first_day,
             second_year, second_month, second_day,
      output ready
   );
endinterface

interface ddd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ddd_pkg::DIFF_W-1:0]  day_difference;

   modport source (output valid, day_difference, input ready);
   modport sink (input valid, day_difference, output ready);
endinterface

// ===== src/ddd_day_count.sv =====
// ----------------------------------------------------------------------------
// ddd_day_count
// Four-stage pipeline from a date to its absolute day count since year 0.
// ----------------------------------------------------------------------------
module ddd_day_count #(
   parameter int MAX_YEAR = 9999
) (
   input  logic                          clock,
   input  logic                          enable,
   input  ddd_pkg::date_type             date,
   output logic [ddd_pkg::COUNT_W-1:0]   count
);

   localparam int YW = ddd_pkg::YEAR_W;
   localparam int SW = ddd_pkg::SUM_W;
   localparam int CW = ddd_pkg::COUNT_W;
   localparam logic [YW+2:0] MaxYearWide  = (YW+3)'(MAX_YEAR);
   localparam logic [YW-1:0] MaxYearClamp = YW'(MAX_YEAR);

   // stage 1: clamp
   logic [YW-1:0]                  year1_ff, year1_in;
   logic [ddd_pkg::MONTH_W-1:0]    month1_ff, month1_in;
   logic [ddd_pkg::DAY_W-1:0]      day1_ff;

   always_comb begin
      year1_in  = ({3'b000, date.year} > MaxYearWide) ? MaxYearClamp : date.year;
      month1_in = (date.month > ddd_pkg::MONTH_DEC) ? ddd_pkg::MONTH_DEC : date.month;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         year1_ff  <= year1_in;
         month1_ff <= month1_in;
         day1_ff   <= date.day;
      end
   end

   // stage 2: centuries by reciprocal multiply
   logic [SW-1:0]                  cent_sum;
   logic [ddd_pkg::PROD_W-1:0]     cent_prod;
   logic [ddd_pkg::CENT_W-1:0]     cent2_ff, cent2_in;
   logic [YW-1:0]                  year2_ff;
   logic [ddd_pkg::MONTH_W-1:0]    month2_ff;
   logic [ddd_pkg::DAY_W-1:0]      day2_ff;

   always_comb begin
      cent_sum  = {1'b0, year1_ff} + ddd_pkg::CENT_ROUND;
      cent_prod = ddd_pkg::PROD_W'(cent_sum) * ddd_pkg::PROD_W'(ddd_pkg::RECIP_100);
      cent2_in  = cent_prod[ddd_pkg::RECIP_SHIFT +: ddd_pkg::CENT_W];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cent2_ff  <= cent2_in;
         year2_ff  <= year1_ff;
         month2_ff <= month1_ff;
         day2_ff   <= day1_ff;
      end
   end

   // stage 3: year days, leap correction, day of year
   logic [CW-1:0]                  years3_ff, years3_in;
   logic [ddd_pkg::QUAD_W-1:0]     corr3_ff, corr3_in;
   logic [ddd_pkg::DOY_W-1:0]      doy3_ff, doy3_in;
   logic [ddd_pkg::QUAD_W-1:0]     quads;
   logic [ddd_pkg::ERA_W-1:0]      eras;
   logic [SW-1:0]                  cent_back;
   logic                           is_cent;
   logic                           is_leap;

   always_comb begin
      years3_in = (CW'(year2_ff) << 8) + (CW'(year2_ff) << 6) + (CW'(year2_ff) << 5)
                + (CW'(year2_ff) << 3) + (CW'(year2_ff) << 2) + CW'(year2_ff);
      quads     = ddd_pkg::QUAD_W'(({1'b0, year2_ff} + ddd_pkg::QUAD_ROUND) >> 2);
      eras      = ddd_pkg::ERA_W'(({1'b0, cent2_ff} + 9'd3) >> 2);
      corr3_in  = quads + ddd_pkg::QUAD_W'(eras) - ddd_pkg::QUAD_W'(cent2_ff);
      cent_back = (SW'(cent2_ff) << 6) + (SW'(cent2_ff) << 5) + (SW'(cent2_ff) << 2);
      is_cent   = (cent_back == {1'b0, year2_ff});
      is_leap   = (year2_ff[1:0] == 2'b00) && (!is_cent || (cent2_ff[1:0] == 2'b00));
      doy3_in   = ddd_pkg::days_before(month2_ff) + ddd_pkg::DOY_W'(day2_ff)
                + ddd_pkg::DOY_W'(is_leap && (month2_ff > ddd_pkg::MONTH_FEB));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         years3_ff <= years3_in;
         corr3_ff  <= corr3_in;
         doy3_ff   <= doy3_in;
      end
   end

   // stage 4: total
   logic [CW-1:0] count4_ff, count4_in;

   assign count4_in = years3_ff + CW'(corr3_ff) + CW'(doy3_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         count4_ff <= count4_in;
      end
   end

   assign count = count4_ff;

endmodule

// ===== src/date_difference_days.sv =====
// ----------------------------------------------------------------------------
// date_difference_days
// Signed day difference between two Gregorian dates, first minus second.
//
// One transaction is accepted every clock cycle unless the result side stalls,
// and it passes through the six register stages: clamp, century reciprocal
// multiply, year and day-of-year terms, day count, subtraction and
// saturation. A stall on the result side freezes every stage together.
// Years above MAX_YEAR are clamped, months above twelve count as December,
// day values are taken as given, and the result saturates to 23 bits.
// ----------------------------------------------------------------------------
module date_difference_days #(
   parameter int MAX_YEAR = 9999
) (
   input  logic      clock,
   input  logic      reset,
   ddd_req_if.sink   req_bus,
   ddd_rsp_if.source rsp_bus
);

   localparam int STAGES = 6;
   localparam int CW     = ddd_pkg::COUNT_W;
   localparam int DW     = ddd_pkg::DIFF_W;

   logic                  enable;
   logic [STAGES-1:0]     valid_ff, valid_in;
   ddd_pkg::date_type     first_date, second_date;
   logic [CW-1:0]         first_count, second_count;
   logic [DW:0]           diff5_ff, diff5_in;
   logic [DW-1:0]         result6_ff, result6_in;

   assign enable        = !valid_ff[STAGES-1] || rsp_bus.ready;
   assign req_bus.ready = enable;

   assign first_date  = '{year: req_bus.first_year, month: req_bus.first_month,
                          day: req_bus.first_day};
   assign second_date = '{year: req_bus.second_year, month: req_bus.second_month,
                          day: req_bus.second_day};

   ddd_day_count #(.MAX_YEAR(MAX_YEAR)) u_first_count (
      .clock  (clock),
      .enable (enable),
      .date   (first_date),
      .count  (first_count)
   );

   ddd_day_count #(.MAX_YEAR(MAX_YEAR)) u_second_count (
      .clock  (clock),
      .enable (enable),
      .date   (second_date),
      .count  (second_count)
   );

   assign valid_in = {valid_ff[STAGES-2:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // subtract, then saturate when the two top bits disagree
   assign diff5_in = {1'b0, first_count} - {1'b0, second_count};

   always_comb begin
      if (diff5_ff[DW] != diff5_ff[DW-1]) begin
         result6_in = diff5_ff[DW] ? ddd_pkg::DIFF_MIN : ddd_pkg::DIFF_MAX;
      end else begin
         result6_in = diff5_ff[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         diff5_ff   <= diff5_in;
         result6_ff <= result6_in;
      end
   end

   assign rsp_bus.valid          = valid_ff[STAGES-1];
   assign rsp_bus.day_difference = result6_ff;

endmodule

// ===== sim/date_difference_days_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_difference_days_test
// Feeds date pairs through date_difference_days and checks every signed day
// difference against a day-count predictor kept in the testbench. Directed
// corner cases come first: leap rules, clamped years and months, day zero and
// days past month end. Random pairs follow, and both sides idle at random.
// ----------------------------------------------------------------------------
module date_difference_days_test;

   localparam int MAX_YEAR     = 9999;
   localparam int RANDOM_ITEMS = 1500;
   localparam int SETTLE       = 20;
   localparam int unsigned MONTH_START [13] =
      '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   typedef struct {
      ddd_pkg::date_type first;
      ddd_pkg::date_type second;
      bit                drain;
   } date_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddd_req_if req_bus ();
   ddd_rsp_if rsp_bus ();

   date_difference_days #(.MAX_YEAR(MAX_YEAR)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   date_pair_type                      pending_pairs [$];
   logic signed [ddd_pkg::DIFF_W-1:0]  expected_diffs [$];
   int unsigned               total_pairs    = 0;
   int unsigned               accepted_pairs = 0;
   int unsigned               mismatch_count = 0;
   int unsigned               sent_pairs     = 0;
   int unsigned               send_gap       = 0;
   int unsigned               stall_left     = 0;
   logic                      req_taken      = 1'b0;
   logic                      rsp_taken      = 1'b0;
   logic                      calm           = 1'b0;

   function automatic ddd_pkg::date_type make_date(input int unsigned y,
                                                   input int unsigned m,
                                                   input int unsigned d);
      ddd_pkg::date_type dt;
      dt.year  = y[ddd_pkg::YEAR_W-1:0];
      dt.month = m[ddd_pkg::MONTH_W-1:0];
      dt.day   = d[ddd_pkg::DAY_W-1:0];
      return dt;
   endfunction

   function automatic bit is_leap(input int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   // days from the start of year zero
   function automatic longint day_count(input ddd_pkg::date_type dt);
      int unsigned y;
      int unsigned m;
      longint      n;
      y = dt.year;
      m = dt.month;
      if (y > MAX_YEAR) y = MAX_YEAR;
      if (m > 12) m = 12;
      n = longint'(y) * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      n += MONTH_START[m] + dt.day;
      if (is_leap(y) && m > 2) n += 1;
      return n;
   endfunction

   function automatic logic signed [ddd_pkg::DIFF_W-1:0] predict_difference(
      input ddd_pkg::date_type a, input ddd_pkg::date_type b);
      longint diff;
      diff = day_count(a) - day_count(b);
      if (diff > longint'($signed(ddd_pkg::DIFF_MAX)))
         diff = longint'($signed(ddd_pkg::DIFF_MAX));
      if (diff < longint'($signed(ddd_pkg::DIFF_MIN)))
         diff = longint'($signed(ddd_pkg::DIFF_MIN));
      return diff[ddd_pkg::DIFF_W-1:0];
   endfunction

   function automatic int unsigned draw_gap();
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic ddd_pkg::date_type random_date();
      int unsigned y;
      int unsigned m;
      int unsigned last;
      y = $urandom_range(1, MAX_YEAR);
      m = $urandom_range(1, 12);
      case (m)
         2:           last = is_leap(y) ? 29 : 28;
         4, 6, 9, 11: last = 30;
         default:     last = 31;
      endcase
      return make_date(y, m, $urandom_range(1, last));
   endfunction

   task automatic add_pair(input ddd_pkg::date_type a, input ddd_pkg::date_type b);
      date_pair_type p;
      p.first  = a;
      p.second = b;
      p.drain  = 1'b0;
      pending_pairs.push_back(p);
      total_pairs++;
   endtask

   task automatic add_drain();
      date_pair_type p;
      p.first  = '0;
      p.second = '0;
      p.drain  = 1'b1;
      pending_pairs.push_back(p);
   endtask

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%t: %s", $realtime, msg);
   endtask

   // driver
   always @(negedge clock) begin : pair_driver
      date_pair_type p;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap      <= send_gap - 1;
         end else if (pending_pairs.size() > 0 && pending_pairs[0].drain) begin
            // hold off until the pipeline has drained
            req_bus.valid <= 1'b0;
            if (expected_diffs.size() == 0) void'(pending_pairs.pop_front());
         end else if (pending_pairs.size() > 0) begin
            p = pending_pairs.pop_front();
            req_bus.first_year   <= p.first.year;
            req_bus.first_month  <= p.first.month;
            req_bus.first_day    <= p.first.day;
            req_bus.second_year  <= p.second.year;
            req_bus.second_month <= p.second.month;
            req_bus.second_day   <= p.second.day;
            req_bus.valid        <= 1'b1;
            send_gap             <= draw_gap();
            sent_pairs++;
            if (sent_pairs % 100 == 0) calm <= ($urandom_range(0, 3) == 0);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin : rsp_pacing
      int unsigned hold;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         hold = rsp_taken ? draw_gap() : stall_left;
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= hold - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left    <= 0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin : diff_checker
      logic signed [ddd_pkg::DIFF_W-1:0] want;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      rsp_taken <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_diffs.push_back(predict_difference(
            make_date(req_bus.first_year, req_bus.first_month, req_bus.first_day),
            make_date(req_bus.second_year, req_bus.second_month, req_bus.second_day)));
         accepted_pairs++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_diffs.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, day_difference %0d",
                                      rsp_bus.day_difference));
         end else begin
            want = expected_diffs.pop_front();
            if (rsp_bus.day_difference !== want)
               report_mismatch($sformatf("day_difference expected %0d, got %0d",
                                         want, rsp_bus.day_difference));
         end
      end
   end

   initial begin : stimulus
      ddd_pkg::date_type a;
      ddd_pkg::date_type b;
      int unsigned       sel;
      int unsigned       y;

      // directed corners
      add_pair(make_date(0, 0, 0), make_date(0, 0, 0));
      add_pair(make_date(9999, 12, 31), make_date(0, 0, 0));
      add_pair(make_date(0, 0, 0), make_date(9999, 12, 31));
      add_pair(make_date(16383, 15, 31), make_date(0, 0, 0));
      add_pair(make_date(0, 1, 1), make_date(16383, 15, 31));
      add_pair(make_date(10000, 1, 1), make_date(9999, 1, 1));
      add_pair(make_date(2000, 3, 1), make_date(2000, 2, 28));
      add_pair(make_date(1900, 3, 1), make_date(1900, 2, 28));
      add_pair(make_date(2100, 3, 1), make_date(2100, 2, 28));
      add_pair(make_date(2004, 3, 1), make_date(2003, 3, 1));
      add_pair(make_date(2023, 2, 31), make_date(2023, 3, 1));
      add_pair(make_date(2024, 0, 5), make_date(2024, 1, 1));
      add_pair(make_date(2024, 13, 1), make_date(2024, 12, 1));
      add_pair(make_date(2024, 15, 31), make_date(2024, 12, 31));
      add_pair(make_date(0, 3, 1), make_date(0, 2, 29));
      add_pair(make_date(1, 1, 1), make_date(0, 12, 31));
      add_pair(make_date(2023, 1, 0), make_date(2022, 12, 31));
      add_pair(make_date(8191, 7, 15), make_date(4096, 8, 16));
      add_pair(make_date(1970, 1, 1), make_date(1970, 1, 1));
      add_pair(make_date(1, 1, 1), make_date(9999, 12, 31));
      add_drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) add_drain();
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            a = random_date();
            b = random_date();
            // keep some pairs close together
            if ($urandom_range(0, 2) == 0) begin
               y = a.year + $urandom_range(0, 2);
               y = (y > 1) ? y - 1 : 1;
               if (y > MAX_YEAR) y = MAX_YEAR;
               b.year = y[ddd_pkg::YEAR_W-1:0];
            end
         end else if (sel < 85) begin
            // around the leap day, on century and four-year boundaries
            y = 100 * $urandom_range(0, 99)
              + ($urandom_range(0, 1) ? 0 : 4 * $urandom_range(0, 24));
            a = make_date(y, $urandom_range(2, 3), $urandom_range(1, 29));
            b = make_date(y + $urandom_range(0, 1) - $urandom_range(0, 1),
                          $urandom_range(2, 3), $urandom_range(1, 29));
            if ($urandom_range(0, 1)) begin
               a = b;
               b = make_date(y, $urandom_range(1, 12), $urandom_range(1, 31));
            end
         end else begin
            a = make_date($urandom_range(0, 16383), $urandom_range(0, 15),
                          $urandom_range(0, 31));
            b = make_date($urandom_range(0, 16383), $urandom_range(0, 15),
                          $urandom_range(0, 31));
         end
         add_pair(a, b);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_pairs < total_pairs) @(posedge clock);
      while (expected_diffs.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
src/ddd_pkg.sv
src/ddd_channels.sv
src/ddd_day_count.sv
src/date_difference_days.sv
sim/date_difference_days_test.sv
